>>> design/deflate_splice_strip_last_align_macros.svh
// Assertion macros shared by the deflate splice block.
`ifndef DEFLATE_SPLICE_STRIP_LAST_ALIGN_MACROS_SVH
`define DEFLATE_SPLICE_STRIP_LAST_ALIGN_MACROS_SVH

// Checks a consequent in the same cycle as its antecedent.
`define DSLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define DSLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dsla_pkg.sv
// Constants and padding tables for the deflate splice block.
package dsla_pkg;

  localparam int unsigned TAIL_BYTES = 8;
  localparam int unsigned CFG_DATA_W = 35;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_BIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BIT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_LENGTH = 2'd3;

  localparam logic [7:0] BYTE_08 = 8'h08;
  localparam logic [7:0] BYTE_20 = 8'h20;
  localparam logic [7:0] BYTE_80 = 8'h80;
  localparam logic [7:0] BYTE_FF = 8'hff;
  localparam logic [7:0] BYTE_00 = 8'h00;

  // Number of words sent for an unaligned stop byte, the byte included.
  function automatic logic [2:0] pad_count(input logic [2:0] off);
    logic [2:0] cnt;
    case (off) inside
      3'd2:    cnt = 3'd4;
      3'd4:    cnt = 3'd3;
      3'd6:    cnt = 3'd2;
      3'd7:    cnt = 3'd6;
      default: cnt = 3'd5;
    endcase
    return cnt;
  endfunction

  // The stop byte itself, with the marker bit set where the offset asks for it.
  function automatic logic [7:0] pad_first(input logic [2:0] off, input logic [7:0] b);
    logic [7:0] res;
    case (off) inside
      3'd2:    res = b | BYTE_08;
      3'd4:    res = b | BYTE_20;
      3'd6:    res = b | BYTE_80;
      default: res = b;
    endcase
    return res;
  endfunction

  // Padding word k (k >= 1) that follows the stop byte.
  function automatic logic [7:0] pad_byte(input logic [2:0] off, input logic [2:0] k);
    logic [7:0] res;
    res = BYTE_00;
    case (off) inside
      3'd2: begin
        case (k) inside
          3'd1:    res = BYTE_20;
          3'd2:    res = BYTE_80;
          default: res = BYTE_00;
        endcase
      end
      3'd4: begin
        case (k) inside
          3'd1:    res = BYTE_80;
          default: res = BYTE_00;
        endcase
      end
      3'd6: begin
        res = BYTE_00;
      end
      3'd7: begin
        case (k) inside
          3'd4, 3'd5: res = BYTE_FF;
          default:    res = BYTE_00;
        endcase
      end
      default: begin
        case (k) inside
          3'd3, 3'd4: res = BYTE_FF;
          default:    res = BYTE_00;
        endcase
      end
    endcase
    return res;
  endfunction

endpackage

>>> design/deflate_splice_strip_last_align.sv
// Top level of the deflate splice block: strips the gzip header, clears the final-block
// flag, pads an unaligned stop byte and reports the trailer CRC and length.
// The block takes one object byte per cycle while in_ready is high. Each accepted byte
// is classified combinationally against its position and becomes a job of zero to six
// words; a job then leaves through the single result register at one word per cycle while
// out_ready is high. Bytes that give zero or one word therefore flow at one byte per cycle,
// while the unaligned stop byte holds the input until its padding burst of 2 to 6 words
// has left on the result port. The final object byte gives a word with has_byte low,
// tail_done high and the trailer fields, after which the position starts again at zero.
`include "deflate_splice_strip_last_align_macros.svh"

module deflate_splice_strip_last_align (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [dsla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsla_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_has_byte,
  output logic [7:0]                         out_byte,
  output logic                               out_run_last,
  output logic                               out_tail_done,
  output logic [31:0]                        out_tail_crc,
  output logic [31:0]                        out_tail_isize
);

  logic [31:0] start_byte_r;
  logic [31:0] last_byte_r;
  logic [2:0]  last_off_r;
  logic [31:0] stop_byte_r;
  logic [2:0]  stop_off_r;
  logic [31:0] obj_len_r;

  logic [31:0] pos_r;
  logic [31:0] pos_nxt;
  logic [7:0]  tail_r   [dsla_pkg::TAIL_BYTES];
  logic [7:0]  tail_nxt [dsla_pkg::TAIL_BYTES];

  logic        job_valid_r;
  logic [2:0]  job_cnt_r;
  logic [2:0]  job_idx_r;
  logic [7:0]  job_byte_r;
  logic [2:0]  job_off_r;
  logic        job_done_r;
  logic [31:0] job_crc_r;
  logic [31:0] job_isize_r;

  logic        out_valid_r;
  logic        out_has_byte_r;
  logic [7:0]  out_byte_r;
  logic        out_run_last_r;
  logic        out_tail_done_r;
  logic [31:0] out_tail_crc_r;
  logic [31:0] out_tail_isize_r;

  logic        job_take;
  logic        job_last;
  logic        job_end;
  logic        in_fire;

  logic [2:0]  cnt_now;
  logic [7:0]  first_now;
  logic        done_now;
  logic        cap_now;
  logic [31:0] tail_idx;
  logic [31:0] pos_inc;

  logic [7:0]  elem_byte;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= '0;
      last_byte_r  <= '0;
      last_off_r   <= '0;
      stop_byte_r  <= '0;
      stop_off_r   <= '0;
      obj_len_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dsla_pkg::CFG_START_BIT: begin
          start_byte_r <= cfg_data[34:3];
        end
        dsla_pkg::CFG_LAST_BIT: begin
          last_byte_r <= cfg_data[34:3];
          last_off_r  <= cfg_data[2:0];
        end
        dsla_pkg::CFG_STOP_BIT: begin
          stop_byte_r <= cfg_data[34:3];
          stop_off_r  <= cfg_data[2:0];
        end
        dsla_pkg::CFG_OBJECT_LENGTH: begin
          obj_len_r <= cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake between the job register and the result register.
  assign job_take = job_valid_r && (!out_valid_r || out_ready);
  assign job_last = (job_idx_r == (job_cnt_r - 3'd1));
  assign job_end  = job_take && job_last;
  assign in_ready = !job_valid_r || job_end;
  assign in_fire  = in_valid && in_ready;

  assign pos_inc  = pos_r + 32'd1;
  assign tail_idx = pos_r + 32'(dsla_pkg::TAIL_BYTES) - obj_len_r;

  // Sort the incoming byte by its position.
  always_comb begin
    cnt_now   = 3'd0;
    first_now = in_byte;
    done_now  = 1'b0;
    cap_now   = 1'b0;
    pos_nxt   = pos_inc;
    if (pos_r < start_byte_r) begin
      cnt_now = 3'd0;
    end else if (pos_r < last_byte_r) begin
      cnt_now = 3'd1;
    end else if (pos_r == last_byte_r) begin
      cnt_now   = 3'd1;
      first_now = in_byte & ~(8'd1 << last_off_r);
    end else if (pos_r < stop_byte_r) begin
      cnt_now = 3'd1;
    end else if ((stop_off_r != 3'd0) && (pos_r == stop_byte_r)) begin
      cnt_now   = dsla_pkg::pad_count(stop_off_r);
      first_now = dsla_pkg::pad_first(stop_off_r, in_byte);
    end else begin
      cap_now = (pos_r < obj_len_r) && (tail_idx[31:3] == '0);
      if (pos_inc == obj_len_r) begin
        cnt_now  = 3'd1;
        done_now = 1'b1;
        pos_nxt  = '0;
      end
    end
  end

  // Trailer bytes with the current byte written through.
  always_comb begin
    for (int i = 0; i < dsla_pkg::TAIL_BYTES; i++) begin
      tail_nxt[i] = (cap_now && (tail_idx[2:0] == 3'(i))) ? in_byte : tail_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_fire) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tail_r <= tail_nxt;
    end
  end

  // Job register: one accepted byte and the words it gives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      job_idx_r   <= '0;
    end else if (in_fire && (cnt_now != 3'd0)) begin
      job_valid_r <= 1'b1;
      job_idx_r   <= '0;
    end else if (job_end) begin
      job_valid_r <= 1'b0;
      job_idx_r   <= '0;
    end else if (job_take) begin
      job_idx_r <= job_idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      job_cnt_r   <= cnt_now;
      job_byte_r  <= first_now;
      job_off_r   <= stop_off_r;
      job_done_r  <= done_now;
      job_crc_r   <= {tail_nxt[3], tail_nxt[2], tail_nxt[1], tail_nxt[0]};
      job_isize_r <= {tail_nxt[7], tail_nxt[6], tail_nxt[5], tail_nxt[4]};
    end
  end

  assign elem_byte = (job_idx_r == 3'd0) ? job_byte_r
                                         : dsla_pkg::pad_byte(job_off_r, job_idx_r);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (job_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      out_has_byte_r   <= !job_done_r;
      out_byte_r       <= job_done_r ? dsla_pkg::BYTE_00 : elem_byte;
      out_run_last_r   <= job_last;
      out_tail_done_r  <= job_done_r;
      out_tail_crc_r   <= job_done_r ? job_crc_r : '0;
      out_tail_isize_r <= job_done_r ? job_isize_r : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_has_byte   = out_has_byte_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_run_last_r;
  assign out_tail_done  = out_tail_done_r;
  assign out_tail_crc   = out_tail_crc_r;
  assign out_tail_isize = out_tail_isize_r;

  `DSLA_ASSERT_NOW(a_job_idx_range, job_valid_r, job_idx_r < job_cnt_r,
    "job word index past its count")
  `DSLA_ASSERT_NOW(a_done_word, out_valid_r && out_tail_done_r,
    !out_has_byte_r && out_run_last_r, "trailer word carries a byte or is not last")
  `DSLA_ASSERT_NEXT(a_pos_restart, in_fire && done_now, pos_r == '0,
    "position did not restart after the final byte")
  `DSLA_ASSERT_NEXT(a_job_hold, job_valid_r && !job_take,
    job_valid_r && $stable(job_idx_r), "stalled job changed")

endmodule
